### rtl/cfb_pkg.sv
// command frame builder package: transaction types, frame constants and codes
// used by every module of the command frame builder; no dependencies
`default_nettype none

package cfb_pkg;

	localparam int unsigned CMD_W   = 24;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned MAX_RUN = 11;
	localparam int unsigned CNT_W   = $clog2(MAX_RUN + 1);
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;

	localparam logic [BYTE_W-1:0] SYNC_A  = 8'h7E;
	localparam logic [BYTE_W-1:0] SYNC_B  = 8'hE7;
	localparam logic [BYTE_W-1:0] TRAILER = 8'h0D;

	localparam logic [CNT_W-1:0] RUN_HEADER = CNT_W'(8);
	localparam logic [CNT_W-1:0] RUN_FULL   = CNT_W'(11);
	localparam logic [CNT_W-1:0] RUN_BYTE   = CNT_W'(1);
	localparam logic [CNT_W-1:0] RUN_CLOSE  = CNT_W'(4);

	typedef enum logic {
		OP_START   = 1'b0,
		OP_PAYLOAD = 1'b1
	} op_t;

	typedef enum logic {
		REG_CMD_A = 1'b0,
		REG_CMD_B = 1'b1
	} reg_sel_t;

	typedef struct packed {
		op_t               operation;
		logic [CMD_W-1:0]  command_code;
		logic [LEN_W-1:0]  payload_length;
		logic [BYTE_W-1:0] payload_byte;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              last_of_run;
	} result_t;

	typedef struct packed {
		logic [MAX_RUN-1:0][BYTE_W-1:0] bytes;
		logic [CNT_W-1:0]               count;
	} run_t;

	typedef struct packed {
		logic [CMD_W-1:0] accepted_command_a;
		logic [CMD_W-1:0] accepted_command_b;
	} cmd_cfg_t;

	typedef struct packed {
		logic frame_open;
		logic frame_rejected;
		logic remaining_zero;
	} status_t;

endpackage

`default_nettype wire

### rtl/cfb_regs.sv
// command frame builder configuration registers behind an apb-style port
// depends on cfb_pkg
`default_nettype none

module cfb_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [cfb_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [cfb_pkg::DATA_W-1:0]   pwdata,
	output logic      [cfb_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output cfb_pkg::cmd_cfg_t                 cfg
);

	logic               wr_en;
	cfb_pkg::reg_sel_t  sel;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign sel    = cfb_pkg::reg_sel_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg <= '0;
		end else if (wr_en) begin
			unique case (sel)
				cfb_pkg::REG_CMD_A: cfg.accepted_command_a <= pwdata[cfb_pkg::CMD_W-1:0];
				cfb_pkg::REG_CMD_B: cfg.accepted_command_b <= pwdata[cfb_pkg::CMD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (sel)
			cfb_pkg::REG_CMD_A: prdata = cfb_pkg::DATA_W'(cfg.accepted_command_a);
			cfb_pkg::REG_CMD_B: prdata = cfb_pkg::DATA_W'(cfg.accepted_command_b);
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/cfb_framer.sv
// command frame builder input stage: registers one transaction, keeps frame
// state and builds the run of bytes it causes; depends on cfb_pkg
`default_nettype none

module cfb_framer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire cfb_pkg::item_t    item,
	input  wire cfb_pkg::cmd_cfg_t cfg,
	input  wire logic              run_free,
	output logic                   run_load,
	output cfb_pkg::run_t          run,
	output cfb_pkg::status_t       status
);

	logic                          valid_s1;
	cfb_pkg::item_t                item_s1;
	logic                          adv;

	logic                          open_q;
	logic                          rejected_q;
	logic [cfb_pkg::LEN_W-1:0]     remaining_q;
	logic [cfb_pkg::BYTE_W-1:0]    xor_q;
	logic [cfb_pkg::BYTE_W-1:0]    sum_q;

	logic                          open_d;
	logic                          rejected_d;
	logic [cfb_pkg::LEN_W-1:0]     remaining_d;
	logic [cfb_pkg::BYTE_W-1:0]    xor_d;
	logic [cfb_pkg::BYTE_W-1:0]    sum_d;

	logic [cfb_pkg::BYTE_W-1:0]    c2, c1, c0, l1, l0, pb;
	logic [cfb_pkg::BYTE_W-1:0]    hdr_xor, hdr_sum, pay_xor, pay_sum;
	logic [cfb_pkg::LEN_W-1:0]     rem_dec;
	logic                          match;
	logic                          len_zero;

	assign c2 = item_s1.command_code[23:16];
	assign c1 = item_s1.command_code[15:8];
	assign c0 = item_s1.command_code[7:0];
	assign l1 = item_s1.payload_length[15:8];
	assign l0 = item_s1.payload_length[7:0];
	assign pb = item_s1.payload_byte;

	assign hdr_xor  = c2 ^ c1 ^ c0 ^ l1 ^ l0;
	assign hdr_sum  = c2 + c1 + c0 + l1 + l0;
	assign pay_xor  = xor_q ^ pb;
	assign pay_sum  = sum_q + pb;
	assign rem_dec  = remaining_q - cfb_pkg::LEN_W'(1);
	assign match    = (item_s1.command_code == cfg.accepted_command_a) ||
	                  (item_s1.command_code == cfg.accepted_command_b);
	assign len_zero = (item_s1.payload_length == '0);

	always_comb begin
		run         = '0;
		open_d      = open_q;
		rejected_d  = rejected_q;
		remaining_d = remaining_q;
		xor_d       = xor_q;
		sum_d       = sum_q;
		unique case (item_s1.operation)
			cfb_pkg::OP_START: begin
				remaining_d = item_s1.payload_length;
				open_d      = match && !len_zero;
				rejected_d  = !match && !len_zero;
				xor_d       = match ? hdr_xor : '0;
				sum_d       = match ? hdr_sum : '0;
				if (match) begin
					run.bytes[0] = cfb_pkg::SYNC_A;
					run.bytes[1] = cfb_pkg::SYNC_B;
					run.bytes[2] = cfb_pkg::SYNC_A;
					run.bytes[3] = c2;
					run.bytes[4] = c1;
					run.bytes[5] = c0;
					run.bytes[6] = l1;
					run.bytes[7] = l0;
					if (len_zero) begin
						run.bytes[8]  = hdr_xor;
						run.bytes[9]  = hdr_sum;
						run.bytes[10] = cfb_pkg::TRAILER;
						run.count     = cfb_pkg::RUN_FULL;
					end else begin
						run.count     = cfb_pkg::RUN_HEADER;
					end
				end
			end
			cfb_pkg::OP_PAYLOAD: begin
				priority if (open_q) begin
					remaining_d  = rem_dec;
					xor_d        = pay_xor;
					sum_d        = pay_sum;
					run.bytes[0] = pb;
					if (rem_dec == '0) begin
						open_d       = 1'b0;
						run.bytes[1] = pay_xor;
						run.bytes[2] = pay_sum;
						run.bytes[3] = cfb_pkg::TRAILER;
						run.count    = cfb_pkg::RUN_CLOSE;
					end else begin
						run.count    = cfb_pkg::RUN_BYTE;
					end
				end else if (rejected_q) begin
					remaining_d = rem_dec;
					if (rem_dec == '0) begin
						rejected_d = 1'b0;
					end
				end else begin
				end
			end
			default: ;
		endcase
	end

	assign adv        = valid_s1 && ((run.count == '0) || run_free);
	assign run_load   = adv && (run.count != '0);
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			open_q      <= 1'b0;
			rejected_q  <= 1'b0;
			remaining_q <= '0;
			xor_q       <= '0;
			sum_q       <= '0;
		end else begin
			if (!valid_s1 || adv) begin
				valid_s1 <= item_valid;
			end
			if (adv) begin
				open_q      <= open_d;
				rejected_q  <= rejected_d;
				remaining_q <= remaining_d;
				xor_q       <= xor_d;
				sum_q       <= sum_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!valid_s1 || adv) begin
			item_s1 <= item;
		end
	end

	assign status.frame_open     = open_q;
	assign status.frame_rejected = rejected_q;
	assign status.remaining_zero = (remaining_q == '0);

endmodule

`default_nettype wire

### rtl/cfb_serializer.sv
// command frame builder output stage: holds one run of bytes and shifts it
// out one result transaction per cycle while result_stall is low; depends on cfb_pkg
`default_nettype none

module cfb_serializer (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     run_load,
	input  wire cfb_pkg::run_t            run,
	output logic                          run_free,
	output logic                          result_valid,
	input  wire logic                     result_stall,
	output cfb_pkg::result_t              result,
	output logic [cfb_pkg::CNT_W-1:0]     run_count
);

	logic [cfb_pkg::MAX_RUN-1:0][cfb_pkg::BYTE_W-1:0] data_q;
	logic [cfb_pkg::CNT_W-1:0]                        cnt_q;
	logic                                             take;

	assign result_valid       = (cnt_q != '0);
	assign take               = result_valid && !result_stall;
	assign run_free           = (cnt_q == '0) || (take && (cnt_q == cfb_pkg::RUN_BYTE));
	assign result.frame_byte  = data_q[0];
	assign result.last_of_run = (cnt_q == cfb_pkg::RUN_BYTE);
	assign run_count          = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (run_load) begin
			cnt_q <= run.count;
		end else if (take) begin
			cnt_q <= cnt_q - cfb_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (run_load) begin
			data_q <= run.bytes;
		end else if (take) begin
			data_q <= {cfb_pkg::BYTE_W'(0), data_q[cfb_pkg::MAX_RUN-1:1]};
		end
	end

endmodule

`default_nettype wire

### rtl/command_frame_builder_top.sv
// command frame builder: an item is registered in the framer, then its run is
// loaded into the serializer and its bytes go out one per cycle unless stalled
// one item per cycle while each item causes at most one byte and no result stall;
// a start item loads a run of 8 or 11 bytes, a closing payload a run of 4
// asynchronous active-low reset clears frame state, registers and all valids
// depends on cfb_pkg, cfb_regs, cfb_framer, cfb_serializer
`default_nettype none

module command_frame_builder_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire cfb_pkg::item_t             item,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output cfb_pkg::result_t                result,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cfb_pkg::ADDR_W-1:0] paddr,
	input  wire logic [cfb_pkg::DATA_W-1:0] pwdata,
	output logic      [cfb_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);

	cfb_pkg::cmd_cfg_t           cfg;
	cfb_pkg::run_t               run;
	cfb_pkg::status_t            status;
	logic                        run_load;
	logic                        run_free;
	logic [cfb_pkg::CNT_W-1:0]   run_count;

	cfb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cfb_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg        (cfg),
		.run_free   (run_free),
		.run_load   (run_load),
		.run        (run),
		.status     (status)
	);

	cfb_serializer u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.run_load     (run_load),
		.run          (run),
		.run_free     (run_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.run_count    (run_count)
	);

`ifndef ASSERT_OFF
	a_open_or_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		!(status.frame_open && status.frame_rejected))
		else $error("frame both open and rejected");

	a_pending_count: assert property (@(posedge clk) disable iff (!arst_n)
		(status.frame_open || status.frame_rejected) |-> !status.remaining_zero)
		else $error("frame pending with no bytes remaining");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_count <= cfb_pkg::RUN_FULL)
		else $error("run longer than a full frame");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		run_load |-> run_free)
		else $error("run loaded over unsent bytes");
`endif

endmodule

`default_nettype wire

### tb/command_frame_builder_checker.sv
// command frame builder checker: keeps its own copy of the frame state and the
// accepted command codes, predicts the bytes of every accepted item and compares
// them in order with the accepted result transactions; depends on cfb_pkg
`default_nettype none

module command_frame_builder_checker
	import cfb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic              item_stall,
	input  wire item_t             item,
	input  wire logic              result_valid,
	input  wire logic              result_stall,
	input  wire result_t           result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	input  wire logic              pready,
	output int unsigned            mismatches,
	output int unsigned            pending,
	output int unsigned            bytes_checked
);

	result_t                expected_bytes[$];
	logic [BYTE_W-1:0]      run_bytes[$];
	logic [CMD_W-1:0]       cmd_a;
	logic [CMD_W-1:0]       cmd_b;
	logic                   frame_open;
	logic                   frame_dropping;
	logic [LEN_W-1:0]       bytes_left;
	logic [BYTE_W-1:0]      run_xor;
	logic [BYTE_W-1:0]      run_sum;
	logic [BYTE_W-1:0]      next_byte;
	logic [CMD_W+LEN_W-1:0] head;
	logic                   closing;
	result_t                want;
	int unsigned            reports;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_a = '0;
			cmd_b = '0;
			frame_open = 1'b0;
			frame_dropping = 1'b0;
			bytes_left = '0;
			run_xor = '0;
			run_sum = '0;
			reports = 0;
			expected_bytes.delete();
			mismatches <= 0;
			pending <= 0;
			bytes_checked <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_sel_t'(paddr[ADDR_W-1:2]))
					REG_CMD_A: cmd_a = pwdata[CMD_W-1:0];
					REG_CMD_B: cmd_b = pwdata[CMD_W-1:0];
				endcase
			end

			if (result_valid && !result_stall) begin
				bytes_checked <= bytes_checked + 1;
				if (expected_bytes.size() == 0) begin
					if (reports < 10)
						$display("unexpected frame byte %02h last %0b", result.frame_byte,
							result.last_of_run);
					reports++;
					mismatches <= mismatches + 1;
				end else begin
					want = expected_bytes.pop_front();
					if (result.frame_byte !== want.frame_byte ||
						result.last_of_run !== want.last_of_run) begin
						if (reports < 10)
							$display("mismatch on frame byte %0d: expected %02h last %0b, got %02h last %0b",
								bytes_checked, want.frame_byte, want.last_of_run,
								result.frame_byte, result.last_of_run);
						reports++;
						mismatches <= mismatches + 1;
					end
				end
			end

			if (item_valid && !item_stall) begin
				run_bytes.delete();
				closing = 1'b0;
				if (item.operation == OP_START) begin
					frame_open = 1'b0;
					frame_dropping = 1'b0;
					run_xor = '0;
					run_sum = '0;
					bytes_left = item.payload_length;
					if (item.command_code != cmd_a && item.command_code != cmd_b) begin
						frame_dropping = (item.payload_length != 0);
					end else begin
						run_bytes.insert(run_bytes.size(), SYNC_A);
						run_bytes.insert(run_bytes.size(), SYNC_B);
						run_bytes.insert(run_bytes.size(), SYNC_A);
						head = {item.command_code, item.payload_length};
						for (int k = 0; k < (CMD_W + LEN_W) / BYTE_W; k++) begin
							next_byte = head[CMD_W+LEN_W-1-BYTE_W*k -: BYTE_W];
							run_xor = run_xor ^ next_byte;
							run_sum = run_sum + next_byte;
							run_bytes.insert(run_bytes.size(), next_byte);
						end
						frame_open = (item.payload_length != 0);
						closing = (item.payload_length == 0);
					end
				end else if (frame_open) begin
					next_byte = item.payload_byte;
					run_xor = run_xor ^ next_byte;
					run_sum = run_sum + next_byte;
					run_bytes.insert(run_bytes.size(), next_byte);
					bytes_left = bytes_left - LEN_W'(1);
					closing = (bytes_left == 0);
				end else if (frame_dropping) begin
					bytes_left = bytes_left - LEN_W'(1);
					frame_dropping = (bytes_left != 0);
				end

				// checksum pair and terminator close the frame
				if (closing) begin
					run_bytes.insert(run_bytes.size(), run_xor);
					run_bytes.insert(run_bytes.size(), run_sum);
					run_bytes.insert(run_bytes.size(), TRAILER);
					frame_open = 1'b0;
				end

				foreach (run_bytes[k]) begin
					want.frame_byte = run_bytes[k];
					want.last_of_run = (k == run_bytes.size() - 1);
					expected_bytes.insert(expected_bytes.size(), want);
				end
			end

			pending <= expected_bytes.size();
		end
	end

endmodule

`default_nettype wire

### tb/command_frame_builder_top_tb.sv
// command frame builder testbench top: clock, reset, command code setup over
// the register port, directed and random frames, random idling on both sides
// depends on cfb_pkg, command_frame_builder_top, command_frame_builder_checker
`default_nettype none

module command_frame_builder_top_tb;
	import cfb_pkg::*;

	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 2000;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 58;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	item_t             item;
	logic              result_valid;
	logic              result_stall;
	result_t           result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int unsigned       mismatches;
	int unsigned       pending;
	int unsigned       bytes_checked;
	int unsigned       items_sent;
	int unsigned       frames_sent;
	int unsigned       settings_used;
	int unsigned       idle_cycles;
	logic [CMD_W-1:0]  cmd_a;
	logic [CMD_W-1:0]  cmd_b;
	bit                calm;
	bit                long_hold_req;

	command_frame_builder_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	command_frame_builder_checker frame_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.pending       (pending),
		.bytes_checked (bytes_checked)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic item_t start_item(input logic [CMD_W-1:0] code,
		input logic [LEN_W-1:0] len);
		item_t it;
		it.operation = OP_START;
		it.command_code = code;
		it.payload_length = len;
		it.payload_byte = BYTE_W'($urandom_range(0, 255));
		return it;
	endfunction

	function automatic item_t payload_item(input logic [BYTE_W-1:0] value);
		item_t it;
		it.operation = OP_PAYLOAD;
		it.command_code = CMD_W'($urandom_range(0, 24'hFFFFFF));
		it.payload_length = LEN_W'($urandom_range(0, 16'hFFFF));
		it.payload_byte = value;
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_frame(input logic [CMD_W-1:0] code, input logic [LEN_W-1:0] len,
		input int n);
		send_item(start_item(code, len));
		for (int k = 0; k < n; k++)
			send_item(payload_item(BYTE_W'($urandom_range(0, 255))));
		frames_sent++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_commands(input logic [CMD_W-1:0] a, input logic [CMD_W-1:0] b);
		reg_sel_t sel;
		for (int k = 0; k < 2; k++) begin
			sel = reg_sel_t'(k);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {sel, 2'b00};
			pwdata <= ($urandom & 32'hFF00_0000) | ((sel == REG_CMD_A) ? a : b);
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cmd_a = a;
		cmd_b = b;
		settings_used++;
	endtask

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("no transaction for %0d cycles", STALL_LIMIT);
			$display("FAIL command_frame_builder_top");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : result_side
		int gap;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				gap = pick_gap();
				if (gap != 0) begin
					result_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
				result_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int               r;
		int               n;
		int               phase_items;
		logic [CMD_W-1:0] code;
		logic [LEN_W-1:0] len;

		items_sent = 0;
		frames_sent = 0;
		settings_used = 0;
		calm = 1'b0;
		long_hold_req = 1'b0;
		cmd_a = '0;
		cmd_b = '0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_commands(24'h000000, 24'hFFFFFF);
		send_frame(24'h000000, 16'h0000, 0);
		send_frame(24'hFFFFFF, 16'h0002, 0);
		send_item(payload_item(8'hFF));
		send_item(payload_item(8'h00));
		// rejected command swallows its payload
		send_frame(24'h123456, 16'h0003, 3);
		send_item(payload_item(8'h55));
		send_frame(24'hA5A5A5, 16'h0000, 0);
		send_item(payload_item(8'hAA));
		// open frame abandoned by a new start
		send_frame(24'hFFFFFF, 16'hFFFF, 0);
		send_item(payload_item(8'h80));
		send_item(payload_item(8'h7F));
		send_frame(24'h000000, 16'h0001, 0);
		send_item(payload_item(8'h01));
		// dropped frame abandoned by a new start
		send_frame(24'h000001, 16'hFFFF, 2);
		send_frame(24'hFFFFFF, 16'h0000, 0);
		send_item(payload_item(8'hFE));

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				1: set_commands(24'hFFFFFF, 24'h000000);
				2: begin
					code = CMD_W'($urandom_range(0, 24'hFFFFFF));
					set_commands(code, code);
				end
				default: set_commands(CMD_W'($urandom_range(0, 24'hFFFFFF)),
					CMD_W'($urandom_range(0, 24'hFFFFFF)));
			endcase
			calm = (p == 3);
			if (p == 1)
				long_hold_req = 1'b1;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 40)
					code = cmd_a;
				else if (r < 80)
					code = cmd_b;
				else if (r < 90)
					code = cmd_a ^ (24'h1 << $urandom_range(0, CMD_W - 1));
				else
					code = CMD_W'($urandom_range(0, 24'hFFFFFF));
				r = $urandom_range(0, 99);
				if (r < 70) begin
					len = LEN_W'($urandom_range(0, 8));
					n = int'(len);
				end else if (r < 85) begin
					if ($urandom_range(0, 2) == 0)
						len = LEN_W'($urandom_range(1, 16'hFFFF));
					else
						len = LEN_W'($urandom_range(1, 12));
					n = $urandom_range(0, (len > 16'd5) ? 5 : int'(len) - 1);
				end else begin
					len = LEN_W'($urandom_range(0, 4));
					n = int'(len) + $urandom_range(1, 3);
				end
				send_frame(code, len, n);
				phase_items += 1 + n;
			end
		end
		calm = 1'b0;
		drain();

		$display("covered %0d items in %0d frames under %0d command code settings",
			items_sent, frames_sent, settings_used);
		$display("checked %0d frame bytes, including a long receiver hold-off", bytes_checked);
		if (mismatches == 0 && pending == 0)
			$display("PASS command_frame_builder_top");
		else
			$display("FAIL command_frame_builder_top");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
rtl/cfb_pkg.sv
rtl/cfb_regs.sv
rtl/cfb_framer.sv
rtl/cfb_serializer.sv
rtl/command_frame_builder_top.sv
tb/command_frame_builder_checker.sv
tb/command_frame_builder_top_tb.sv
